// ===== design/irpw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse width decoder package
// Shared payload types, operation codes, register indexes and constants.
// ----------------------------------------------------------------------------
package irpw_pkg;

   typedef struct packed {
      logic       kind;
      logic [7:0] mark_width;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       command_stored;
   } rsp_type;

   // Classified operation handed from the front end to the back end.
   typedef enum logic [1:0] {
      OP_BIT0  = 2'd0,
      OP_BIT1  = 2'd1,
      OP_START = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef struct packed {
      logic [7:0] zero_threshold;
      logic [7:0] one_threshold;
      logic [7:0] address_a;
      logic [7:0] address_b;
      logic [7:0] address_c;
   } cfg_type;

   typedef struct packed {
      logic exec;
      logic store;
   } back_status_type;

   localparam logic [2:0] CSR_ZERO_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_ONE_THRESHOLD  = 3'd1;
   localparam logic [2:0] CSR_ADDRESS_A      = 3'd2;
   localparam logic [2:0] CSR_ADDRESS_B      = 3'd3;
   localparam logic [2:0] CSR_ADDRESS_C      = 3'd4;

   localparam logic [7:0] RESET_ZERO_THRESHOLD = 8'd14;
   localparam logic [7:0] RESET_ONE_THRESHOLD  = 8'd30;
   localparam logic [7:0] RESET_ADDRESS_A      = 8'd26;
   localparam logic [7:0] RESET_ADDRESS_B      = 8'd17;
   localparam logic [7:0] RESET_ADDRESS_C      = 8'd1;

   localparam logic [3:0] COMMAND_BITS = 4'd7;
   localparam logic [3:0] FRAME_BITS   = 4'd12;
   localparam logic [3:0] COUNT_LIMIT  = 4'd13;
   localparam logic [7:0] EMPTY_CODE   = 8'hFF;

endpackage

// ===== design/ir_pulse_width_command_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse width command decoder
// Decodes 12-bit pulse-width remote frames and serves queued commands.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while rsp_stall stays low and
// the queue is not full, and gives one result for each. The accepting edge
// writes the operation into the two-entry operation queue. When the back end
// takes it from the queue, it runs through the back end, whose frame state and
// ring pointers update together and whose registered ring read forms the
// result stage. The command ring holds RING_DEPTH entries, has no reset and
// needs no clearing pass after reset; writes do not check for a full ring, so
// an overrun makes it look empty. The user must write thresholds and addresses
// through the csr port only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module ir_pulse_width_command_decoder
   import irpw_pkg::*;
#(
   parameter int RING_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);

   cfg_type         cfg_ff;
   cfg_type         cfg_in;
   op_type          front_op;
   op_type          q_op;
   logic            q_full;
   logic            q_valid;
   logic            q_pop;
   back_status_type back_status;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ZERO_THRESHOLD: cfg_in.zero_threshold = csr_data;
            CSR_ONE_THRESHOLD:  cfg_in.one_threshold  = csr_data;
            CSR_ADDRESS_A:      cfg_in.address_a      = csr_data;
            CSR_ADDRESS_B:      cfg_in.address_b      = csr_data;
            CSR_ADDRESS_C:      cfg_in.address_c      = csr_data;
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_threshold <= RESET_ZERO_THRESHOLD;
         cfg_ff.one_threshold  <= RESET_ONE_THRESHOLD;
         cfg_ff.address_a      <= RESET_ADDRESS_A;
         cfg_ff.address_b      <= RESET_ADDRESS_B;
         cfg_ff.address_c      <= RESET_ADDRESS_C;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   irpw_front u_front (
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .op          (front_op)
   );

   irpw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_op   (front_op),
      .full      (q_full),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_op    (q_op)
   );

   irpw_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .op_valid    (q_valid),
      .op          (q_op),
      .op_pop      (q_pop),
      .status      (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   // A full queue always has an operation on offer to the back end.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> q_valid)
      else $error("queue full without a pending operation");

   // A queued command shows up as the next result, flagged as stored.
   assert property (@(posedge clock) disable iff (reset)
      back_status.store |=> rsp_valid && rsp_payload.command_stored)
      else $error("stored command not reported");

   // The back end never overwrites a result that is still stalled.
   assert property (@(posedge clock) disable iff (reset)
      back_status.exec |-> !(rsp_valid && rsp_stall))
      else $error("result overwritten while stalled");

   // Reset empties both the queue and the result stage.
   assert property (@(posedge clock) reset |=> !rsp_valid && !q_valid)
      else $error("pipeline not empty after reset");
`endif

endmodule

// ===== design/irpw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse width decoder front end
// Classifies each incoming transaction as a zero bit, one bit, start mark or
// read request against the configured thresholds.
// ----------------------------------------------------------------------------
module irpw_front
   import irpw_pkg::*;
(
   input  req_type req_payload,
   input  cfg_type cfg,
   output op_type  op
);

   always_comb begin
      if (req_payload.kind) begin
         op = OP_READ;
      end else if (req_payload.mark_width < cfg.zero_threshold) begin
         op = OP_BIT0;
      end else if (req_payload.mark_width < cfg.one_threshold) begin
         op = OP_BIT1;
      end else begin
         op = OP_START;
      end
   end

endmodule

// ===== design/irpw_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse width decoder operation queue
// Two-entry queue of classified operations between front and back ends.
// ----------------------------------------------------------------------------
module irpw_queue
   import irpw_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output logic   out_valid,
   output op_type out_op
);

   localparam int QUEUE_DEPTH = 2;

   op_type     slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full      = (count_ff == 2'(QUEUE_DEPTH));
   assign out_valid = (count_ff != 2'd0);
   assign out_op    = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== design/irpw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse width decoder back end
// Assembles frames from bit operations, queues matching commands in the ring
// and serves read requests through a registered result stage.
// ----------------------------------------------------------------------------
module irpw_back
   import irpw_pkg::*;
#(
   parameter int RING_DEPTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            op_valid,
   input  op_type          op,
   output logic            op_pop,
   output back_status_type status,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp_payload
);

   localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_DEPTH - 1);

   logic [6:0]       ring_ff [RING_DEPTH];
   logic [6:0]       rd_data_ff;
   logic [6:0]       command_ff;
   logic [6:0]       command_in;
   logic [7:0]       address_ff;
   logic [7:0]       address_in;
   logic [3:0]       count_ff;
   logic [3:0]       count_in;
   logic [IDX_W-1:0] wr_idx_ff;
   logic [IDX_W-1:0] wr_idx_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [IDX_W-1:0] rd_idx_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             hit_ff;
   logic             hit_in;
   logic             stored_ff;
   logic             stored_in;
   logic             exec;
   logic             is_bit;
   logic             bit_value;
   logic             store;
   logic             read_hit;
   logic             addr_match;
   logic [3:0]       addr_pos;

   // An operation runs only when the result register is free or draining.
   assign exec      = op_valid && (!rsp_valid_ff || !rsp_stall);
   assign op_pop    = exec;
   assign is_bit    = (op == OP_BIT0) || (op == OP_BIT1);
   assign bit_value = (op == OP_BIT1);
   assign addr_pos  = count_ff - COMMAND_BITS;

   always_comb begin
      command_in = command_ff;
      address_in = address_ff;
      count_in   = count_ff;
      if (exec && (op == OP_START)) begin
         command_in = 7'd0;
         address_in = 8'd0;
         count_in   = 4'd0;
      end else if (exec && is_bit && (count_ff < COUNT_LIMIT)) begin
         count_in = count_ff + 4'd1;
         if (count_ff < COMMAND_BITS) begin
            command_in[count_ff[2:0]] = bit_value;
         end else begin
            address_in[addr_pos[2:0]] = bit_value;
         end
      end
   end

   assign addr_match = (address_in == cfg.address_a) || (address_in == cfg.address_b) ||
                       (address_in == cfg.address_c);
   // Only the bit that takes the count from eleven to twelve completes a frame.
   assign store    = exec && is_bit && (count_ff == FRAME_BITS - 4'd1) && addr_match;
   assign read_hit = exec && (op == OP_READ) && (wr_idx_ff != rd_idx_ff);

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      if (store) begin
         wr_idx_in = (wr_idx_ff == LAST_SLOT) ? '0 : wr_idx_ff + IDX_W'(1);
      end
      if (read_hit) begin
         rd_idx_in = (rd_idx_ff == LAST_SLOT) ? '0 : rd_idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      if (exec) begin
         rsp_valid_in = 1'b1;
         hit_in       = read_hit;
         stored_in    = store;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         hit_in       = hit_ff;
         stored_in    = stored_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff   <= 7'd0;
         address_ff   <= 8'd0;
         count_ff     <= 4'd0;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         stored_ff    <= 1'b0;
      end else begin
         command_ff   <= command_in;
         address_ff   <= address_in;
         count_ff     <= count_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         stored_ff    <= stored_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         ring_ff[wr_idx_ff] <= command_in;
      end
   end

   always_ff @(posedge clock) begin
      if (read_hit) begin
         rd_data_ff <= ring_ff[rd_idx_ff];
      end
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_payload.read_data      = hit_ff ? {1'b0, rd_data_ff} : EMPTY_CODE;
   assign rsp_payload.command_stored = stored_ff;
   assign status.exec                = exec;
   assign status.store               = store;

endmodule
